### design/hsb_pkg.sv
package hsb_pkg;

  // longest string the block decodes, in bytes
  localparam int MAX_BYTES = 16;

  // byte counter holds 0..MAX_BYTES and is never narrower than the register
  localparam int CNT_BITS  = $clog2(MAX_BYTES + 1);
  localparam int CNT_W     = (CNT_BITS > 5) ? CNT_BITS : 5;

  localparam int CHAR_W    = 8;
  localparam int NIB_W     = 4;
  localparam int IDX_W     = 4;
  localparam int EXP_W     = 5;
  localparam int PACK_W    = 64;
  localparam int STAT_W    = 3;

  localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(16);

  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_TOOMANY = 3'd2,
    ST_ODD     = 3'd3,
    ST_TOOFEW  = 3'd4
  } status_t;

  // character class from the classifier
  typedef struct packed {
    logic             is_skip;
    logic             is_hex;
    logic [NIB_W-1:0] nibble;
  } char_class_t;

  // one result item
  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        byte_value;
    logic [IDX_W-1:0]  byte_index;
    logic              finished;
    status_t           status;
    logic [PACK_W-1:0] packed_value;
  } hsb_res_t;

endpackage

### design/hsb_if.sv
interface hsb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source(output valid, output char_code, output end_of_string, input ready);
  modport sink(input valid, input char_code, input end_of_string, output ready);
endinterface

interface hsb_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic [3:0]  byte_index;
  logic        finished;
  logic [2:0]  status;
  logic [63:0] packed_value;

  modport source(output valid, output byte_valid, output byte_value, output byte_index,
                 output finished, output status, output packed_value, input ready);
  modport sink(input valid, input byte_valid, input byte_value, input byte_index,
               input finished, input status, input packed_value, output ready);
endinterface

### design/hsb_classify.sv
module hsb_classify
  import hsb_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output char_class_t       cls
);

  logic is_dec;
  logic is_lo;
  logic is_up;
  logic [CHAR_W-1:0] off;

  always_comb begin
    is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_lo  = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
    is_up  = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);

    if (is_dec) begin
      off = char_code - CH_ZERO;
    end else if (is_lo) begin
      off = char_code - CH_LO_A + CHAR_W'(10);
    end else begin
      off = char_code - CH_UP_A + CHAR_W'(10);
    end

    cls.is_skip = (char_code == CH_COLON) || (char_code == CH_SPACE) ||
                  (char_code == CH_DASH);
    cls.is_hex  = is_dec || is_lo || is_up;
    cls.nibble  = off[NIB_W-1:0];
  end

endmodule

### design/hsb_decode.sv
module hsb_decode
  import hsb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             eos,
  input  char_class_t      cls,
  input  logic [EXP_W-1:0] expected,
  output hsb_res_t         res
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

  logic              nibble_pending_r, nibble_pending_nxt;
  logic [NIB_W-1:0]  held_nibble_r, held_nibble_nxt;
  logic [CNT_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  status_t           fault_r, fault_nxt;
  logic [PACK_W-1:0] packed_r, packed_nxt;

  logic [CNT_W-1:0]  exp_ext;
  logic [CNT_W-1:0]  limit;
  logic [7:0]        new_byte;

  always_comb begin
    exp_ext  = CNT_W'(expected);
    limit    = (exp_ext < MAX_CNT) ? exp_ext : MAX_CNT;
    new_byte = {held_nibble_r, cls.nibble};

    nibble_pending_nxt = nibble_pending_r;
    held_nibble_nxt    = held_nibble_r;
    bytes_seen_nxt     = bytes_seen_r;
    fault_nxt          = fault_r;
    packed_nxt         = packed_r;

    res.byte_valid   = 1'b0;
    res.byte_value   = '0;
    res.byte_index   = '0;
    res.finished     = 1'b0;
    res.status       = fault_r;
    res.packed_value = packed_r;

    if (eos) begin
      // verdict: sticky fault, then dangling nibble, then length mismatch
      res.finished = 1'b1;
      if (fault_r != ST_OK) begin
        res.status = fault_r;
      end else if (nibble_pending_r) begin
        res.status = ST_ODD;
      end else if (bytes_seen_r != exp_ext) begin
        res.status = ST_TOOFEW;
      end else begin
        res.status = ST_OK;
      end
      nibble_pending_nxt = 1'b0;
      held_nibble_nxt    = '0;
      bytes_seen_nxt     = '0;
      fault_nxt          = ST_OK;
      packed_nxt         = '0;
    end else begin
      if ((fault_r == ST_OK) && !cls.is_skip) begin
        if (!cls.is_hex) begin
          fault_nxt = ST_BADCHAR;
        end else if (!nibble_pending_r) begin
          held_nibble_nxt    = cls.nibble;
          nibble_pending_nxt = 1'b1;
        end else if (bytes_seen_r >= limit) begin
          fault_nxt = ST_TOOMANY;
        end else begin
          res.byte_valid     = 1'b1;
          res.byte_value     = new_byte;
          res.byte_index     = bytes_seen_r[IDX_W-1:0];
          packed_nxt         = {packed_r[PACK_W-9:0], new_byte};
          bytes_seen_nxt     = bytes_seen_r + CNT_W'(1);
          nibble_pending_nxt = 1'b0;
          held_nibble_nxt    = '0;
        end
      end
      res.status       = fault_nxt;
      res.packed_value = packed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_pending_r <= 1'b0;
      held_nibble_r    <= '0;
      bytes_seen_r     <= '0;
      fault_r          <= ST_OK;
      packed_r         <= '0;
    end else if (step) begin
      nibble_pending_r <= nibble_pending_nxt;
      held_nibble_r    <= held_nibble_nxt;
      bytes_seen_r     <= bytes_seen_nxt;
      fault_r          <= fault_nxt;
      packed_r         <= packed_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= MAX_CNT)
    else $error("byte count beyond limit");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.byte_valid |=> bytes_seen_r == CNT_W'($past(bytes_seen_r) + CNT_W'(1)))
    else $error("byte count did not advance on emitted byte");

  a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && eos |=> (bytes_seen_r == '0) && !nibble_pending_r && (fault_r == ST_OK))
    else $error("string state not cleared after terminator");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != ST_OK) |-> !res.byte_valid)
    else $error("byte emitted after fault");
`endif

endmodule

### design/hex_string_to_bytes.sv
// result path: an accepted input is held in the input register, then its result in the result register
// throughput: one item per cycle, sustained while the result side keeps ready high
// a waiting result lets the input register take one more request, then input stalls
// reset: synchronous active-low rst_n clears the string state, both valid flags,
// and sets expected_r to 16
module hex_string_to_bytes
  import hsb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  hsb_in_if.sink           in_chan,
  hsb_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [EXP_W-1:0] cfg_wdata
);

  // configuration register
  logic [EXP_W-1:0] expected_r;

  // input register
  logic              in_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              eos_r;

  // result register
  logic     out_valid_r;
  hsb_res_t res_r;

  char_class_t cls;
  hsb_res_t    res;
  logic        advance;
  logic        in_take;

  // the held request moves on when the result register is empty or draining
  assign advance  = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_take  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= EXP_RESET;
    end else if (cfg_we) begin
      expected_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_chan.char_code;
      eos_r  <= in_chan.end_of_string;
    end
  end

  // classify the held character: skip, hex digit or bad
  hsb_classify u_classify (
    .char_code (char_r),
    .cls       (cls)
  );

  // nibble pairing, byte count, sticky fault and packed value
  hsb_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .eos      (eos_r),
    .cls      (cls),
    .expected (expected_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.byte_valid   = res_r.byte_valid;
  assign out_chan.byte_value   = res_r.byte_value;
  assign out_chan.byte_index   = res_r.byte_index;
  assign out_chan.finished     = res_r.finished;
  assign out_chan.status       = res_r.status;
  assign out_chan.packed_value = res_r.packed_value;

`ifndef SYNTH
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> in_valid_r && out_valid_r && !out_chan.ready)
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request left no result");

  a_finished_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.finished |-> !res_r.byte_valid)
    else $error("terminator result carries a byte");
`endif

endmodule
